[sv/lpd_pkg.sv]
// Package for the length-prefix deframer: constants, widths and the result kind codes.
`default_nettype none
package lpd_pkg;

    // Largest payload length that a frame may announce.
    localparam int unsigned MAX_PAYLOAD = 4096;
    // Width of the frame length and payload counters (holds 0..MAX_PAYLOAD).
    localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
    // Number of bytes in the length prefix.
    localparam int unsigned HDR_BYTES = 4;

    // Configuration register indexes.
    typedef enum logic {
        CFG_AUTHORIZED     = 1'b0,
        CFG_MAX_UNAUTH_LEN = 1'b1
    } t_cfg_index;

    // Kind of a result transaction.
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_DESYNC   = 2'd2
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       frame_last;
    } t_result;

endpackage
`default_nettype wire

[sv/length_prefix_deframer.sv]
// Length-prefix deframer: strips 4-byte big-endian length headers from a byte stream.
`default_nettype none
// The block takes one received byte per input transaction and accepts a new byte in
// every unstalled cycle. Each frame starts with a four-byte big-endian signed length; the
// following bytes of the frame leave as data results (kind 0), with frame_last set on
// the final one. Header bytes and zero-length frames produce no result. When the fourth
// header byte arrives the length is checked against the configuration: if the block is
// not authorized, max_unauth_len is non-negative and the length is above it, one
// overflow result (kind 1) is sent; otherwise a negative length or one above
// MAX_PAYLOAD sends one desync result (kind 2). After either error every further byte
// is dropped until reset. A result is registered when its byte is accepted. The output
// side has a result register followed by a one-entry skid stage, so a byte is still
// taken while a result waits; input stall rises only when both are full, and the
// sustained rate is one byte per cycle as long as results are taken.
// Configuration writes take effect at the next edge and are sampled by the length check.
module length_prefix_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Received byte channel.
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic             o_frame_last
);
    import lpd_pkg::*;

    // Configuration registers.
    logic        r_authorized;
    logic [31:0] r_max_unauth_len;

    // Deframer state.
    logic [23:0]      r_hdr_shift;   // Only the low three bytes matter before the fourth.
    logic [1:0]       r_hdr_cnt;
    logic [LEN_W-1:0] r_frame_len;
    logic [LEN_W-1:0] r_pay_cnt;
    logic             r_halted;

    logic [23:0]      n_hdr_shift;
    logic [1:0]       n_hdr_cnt;
    logic [LEN_W-1:0] n_frame_len;
    logic [LEN_W-1:0] n_pay_cnt;
    logic             n_halted;

    // Output register and skid stage.
    logic    r_out_valid;
    t_result r_out;
    logic    r_sk_valid;
    t_result r_sk;

    logic    rx_accept;
    logic    out_take;
    logic    res_valid;
    t_result res;

    logic [31:0]      hdr_len;
    logic [LEN_W-1:0] pay_cnt_inc;
    logic             len_overflow;
    logic             len_desync;

    assign o_rx_stall = r_sk_valid;
    assign rx_accept  = i_rx_valid && !r_sk_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    // The complete length once the fourth byte is in.
    assign hdr_len     = {r_hdr_shift, i_rx_byte};
    assign pay_cnt_inc = r_pay_cnt + LEN_W'(1);

    // Overflow: with a non-negative limit, a negative length can never exceed it,
    // so the signed compare reduces to an unsigned one on the low 31 bits.
    assign len_overflow = !r_authorized && !r_max_unauth_len[31] && !hdr_len[31]
                          && (hdr_len[30:0] > r_max_unauth_len[30:0]);
    assign len_desync   = hdr_len[31] || (hdr_len[30:0] > 31'(MAX_PAYLOAD));

    // Per-byte step: decide the result and the next deframer state.
    always_comb begin
        n_hdr_shift = r_hdr_shift;
        n_hdr_cnt   = r_hdr_cnt;
        n_frame_len = r_frame_len;
        n_pay_cnt   = r_pay_cnt;
        n_halted    = r_halted;
        res_valid   = 1'b0;
        res         = '{kind: KIND_DATA, payload_byte: 8'd0, frame_last: 1'b0};
        if (rx_accept && !r_halted) begin
            if (r_frame_len != '0) begin
                // Payload byte: pass it through, close the frame on the last one.
                res_valid        = 1'b1;
                res.payload_byte = i_rx_byte;
                if (pay_cnt_inc >= r_frame_len) begin
                    res.frame_last = 1'b1;
                    n_frame_len    = '0;
                    n_pay_cnt      = '0;
                end else begin
                    n_pay_cnt = pay_cnt_inc;
                end
            end else if (r_hdr_cnt != 2'(HDR_BYTES - 1)) begin
                n_hdr_shift = {r_hdr_shift[15:0], i_rx_byte};
                n_hdr_cnt   = r_hdr_cnt + 2'd1;
            end else begin
                // Fourth header byte: check the length.
                n_hdr_shift = {r_hdr_shift[15:0], i_rx_byte};
                n_hdr_cnt   = '0;
                n_pay_cnt   = '0;
                if (len_overflow) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_OVERFLOW;
                    n_halted  = 1'b1;
                end else if (len_desync) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_DESYNC;
                    n_halted  = 1'b1;
                end else begin
                    n_frame_len = hdr_len[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_authorized     <= 1'b0;
            r_max_unauth_len <= '1;
            r_hdr_shift      <= '0;
            r_hdr_cnt        <= '0;
            r_frame_len      <= '0;
            r_pay_cnt        <= '0;
            r_halted         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_AUTHORIZED:     r_authorized     <= i_cfg_data[0];
                    CFG_MAX_UNAUTH_LEN: r_max_unauth_len <= i_cfg_data;
                    default: ;
                endcase
            end
            r_hdr_shift <= n_hdr_shift;
            r_hdr_cnt   <= n_hdr_cnt;
            r_frame_len <= n_frame_len;
            r_pay_cnt   <= n_pay_cnt;
            r_halted    <= n_halted;
        end
    end

    // Output buffering. While the skid stage is full no byte is accepted, so the
    // only movement is skid into the output register once the output is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (out_take) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (out_take) begin
                r_out <= r_sk;
            end
        end else if (!r_out_valid || out_take) begin
            r_out <= res;
        end else if (res_valid) begin
            r_sk <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_last   = r_out.frame_last;

`ifndef NO_ASSERTIONS
    // Only reset leaves the halted state.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted state cleared without reset");

    // An error result on the output means the deframer has halted.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != KIND_DATA)) |-> r_halted)
        else $error("error result without halt");

    // The header is never partly gathered while a payload is in progress.
    a_hdr_idle_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_len != '0) |-> (r_hdr_cnt == '0))
        else $error("header count nonzero during payload");

    // The skid stage is only filled behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid stage full with empty output register");
`endif

endmodule
`default_nettype wire

[tb/tb_length_prefix_deframer.sv]
// Self-checking testbench for the length-prefix deframer, with a result-predicting scoreboard.
module tb_length_prefix_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    // The stimulus walks through the deframer in phases. A short directed part sends
    // frames of length zero, one and a few bytes with extreme payload values. Each
    // later phase writes both configuration registers while the block is idle and
    // then sends well-formed frames whose lengths respect the current limit, so that
    // the block keeps streaming payload. One phase carries a long frame sent back to
    // back, during which the result side holds off for a long stretch to fill the
    // output stage and push back on the byte input. An error halts the block until
    // reset, and reset is applied only once, so the run ends with one bad header (an
    // overflow or a desync, picked at random) followed by bytes that must be dropped.

    localparam int unsigned RANDOM_BYTES = 280;
    localparam int unsigned HOLD_FRAME_LEN = 128;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;

    // The scoreboard mirrors the deframer state and keeps the results that are
    // still owed by the block, oldest first.
    class frame_scoreboard;
        logic        authorized;
        logic [31:0] max_unauth_len;
        logic [31:0] header_word;
        int unsigned header_bytes;
        int unsigned frame_len;
        int unsigned payload_seen;
        bit          halted;
        t_result     owed_results[$];
        int unsigned errors;

        function new();
            authorized     = 1'b0;
            max_unauth_len = 32'hFFFF_FFFF;
            header_word    = '0;
            header_bytes   = 0;
            frame_len      = 0;
            payload_seen   = 0;
            halted         = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [31:0] data);
            case (idx)
                CFG_AUTHORIZED:     authorized = data[0];
                CFG_MAX_UNAUTH_LEN: max_unauth_len = data;
                default: ;
            endcase
        endfunction

        // Called for every accepted byte transaction.
        function void note_byte(logic [7:0] b);
            t_result r;
            int      len;
            int      lim;
            if (halted)
                return;
            r.payload_byte = '0;
            r.frame_last   = 1'b0;
            if (frame_len != 0) begin
                payload_seen++;
                r.kind         = KIND_DATA;
                r.payload_byte = b;
                r.frame_last   = (payload_seen >= frame_len);
                if (r.frame_last) begin
                    frame_len    = 0;
                    payload_seen = 0;
                end
                owed_results.push_back(r);
                return;
            end
            header_word = {header_word[23:0], b};
            header_bytes++;
            if (header_bytes < HDR_BYTES)
                return;
            header_bytes = 0;
            payload_seen = 0;
            len = $signed(header_word);
            lim = $signed(max_unauth_len);
            // The unauthorized limit is checked before the sanity check on the length.
            if (!authorized && lim >= 0 && len > lim) begin
                halted = 1'b1;
                r.kind = KIND_OVERFLOW;
                owed_results.push_back(r);
            end else if (len < 0 || len > int'(MAX_PAYLOAD)) begin
                halted = 1'b1;
                r.kind = KIND_DESYNC;
                owed_results.push_back(r);
            end else begin
                frame_len = len;
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            t_result want;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                             $realtime, kind, data, last);
                return;
            end
            want = owed_results.pop_front();
            if (kind !== want.kind || data !== want.payload_byte || last !== want.frame_last)
            begin
                errors++;
                if (errors <= 10) begin
                    $write("%0t: result mismatch: expected kind=%0d byte=%02h last=%0b",
                           $realtime, want.kind, want.payload_byte, want.frame_last);
                    $display(", got kind=%0d byte=%02h last=%0b", kind, data, last);
                end
            end
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function int unsigned close_out();
            if (owed_results.size() != 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %0d results never arrived", $realtime, owed_results.size());
            end
            return errors;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_AUTHORIZED;
    logic [31:0] i_cfg_data = '0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic        o_frame_last;

    frame_scoreboard sb = new();

    bit          sender_dense = 1'b0;
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;

    length_prefix_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last)
    );

    always #10 i_clk = ~i_clk;

    // Monitors sample at the rising edge, before the block updates its registers.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (i_rx_valid && !o_rx_stall)
                sb.note_byte(i_rx_byte);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_kind, o_payload_byte, o_frame_last);
        end
    end

    // The watchdog ends a run in which neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_rx_valid && !o_rx_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // The result side stalls in runs: mostly free-flowing, sometimes briefly stalled,
    // now and then for a long while, and once for a very long hold when armed.
    initial begin
        int unsigned run;
        int unsigned pick;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_armed && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    i_out_stall <= 1'b0;
                    run = $urandom_range(1, 30);
                end else if (pick < 9) begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    run = $urandom_range(10, 40);
                end
                repeat (run) @(negedge i_clk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned pick;
        if (sender_dense)
            return 0;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 0;
        if (pick < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_header(input logic [31:0] len_word);
        for (int i = HDR_BYTES - 1; i >= 0; i--)
            send_byte(len_word[8*i +: 8]);
    endtask

    task automatic send_frame(input int unsigned len);
        send_header(len);
        repeat (len)
            send_byte(8'($urandom));
    endtask

    // Lets the block finish every owed result, then idles on past a trailing
    // header byte that produces nothing.
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic auth, input logic [31:0] limit);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_AUTHORIZED;
        i_cfg_data  <= {31'd0, auth};
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_UNAUTH_LEN;
        i_cfg_data  <= limit;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 6))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom_range(1, 20);
            3: return 32'h7FFF_FFFF;
            4: return $urandom;
            5: return MAX_PAYLOAD;
            default: return $urandom_range(21, 300);
        endcase
    endfunction

    // Largest length that the current settings let through without an error.
    function automatic int unsigned length_cap(input logic auth, input logic [31:0] limit);
        if (auth || limit[31] || limit > MAX_PAYLOAD)
            return MAX_PAYLOAD;
        return limit;
    endfunction

    // Mostly short frames, with empty frames and frames right at the cap mixed in.
    function automatic int unsigned pick_length(input int unsigned cap);
        int unsigned pick;
        if (cap == 0)
            return 0;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 0;
        if (pick == 1 && cap <= 64)
            return cap;
        if (pick == 2)
            return $urandom_range(0, (cap > 200) ? 200 : cap);
        return $urandom_range(1, (cap < 12) ? cap : 12);
    endfunction

    initial begin
        logic [31:0] limit;
        logic [31:0] bad_len;
        logic        auth;
        int unsigned random_start;
        int unsigned budget;
        bit          big_done;
        big_done = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames under the reset settings: single-byte, empty and short
        // frames carrying all-zero, all-one and alternating payload bytes.
        send_header(32'd1);
        send_byte(8'h00);
        send_header(32'd0);
        send_header(32'd2);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_header(32'd3);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);

        // A frame exactly at the unauthorized limit, then a limit of zero that only
        // empty frames can pass, then the authorized case with a zero limit.
        configure(1'b0, 32'd16);
        send_frame(16);
        configure(1'b0, 32'd0);
        send_frame(0);
        configure(1'b1, 32'd0);
        send_frame(5);
        configure(1'b0, 32'h7FFF_FFFF);
        send_frame(7);

        // Random phases: new settings each time, then well-formed frames within them.
        random_start = bytes_sent;
        budget = RANDOM_BYTES;
        while (bytes_sent - random_start < budget) begin
            auth  = $urandom_range(0, 1);
            limit = pick_limit();
            configure(auth, limit);
            repeat ($urandom_range(3, 10)) begin
                sender_dense = ($urandom_range(0, 3) == 0);
                send_frame(pick_length(length_cap(auth, limit)));
            end
            // Once, a long frame streams back to back while the result side holds off.
            if (!big_done && bytes_sent - random_start >= RANDOM_BYTES / 2) begin
                configure(1'b1, $urandom);
                sender_dense = 1'b1;
                hold_armed   = 1'b1;
                send_frame(HOLD_FRAME_LEN);
                big_done = 1'b1;
                budget   = budget + HOLD_FRAME_LEN + HDR_BYTES;
            end
        end

        // The closing error. Overflow takes precedence even for lengths that would
        // also fail the sanity check; desync is reached with the limit out of play.
        sender_dense = 1'b0;
        if ($urandom_range(0, 1) == 0) begin
            limit = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20)
                                                : $urandom_range(21, 5000);
            configure(1'b0, limit);
            send_frame(pick_length(length_cap(1'b0, limit)));
            bad_len = ($urandom_range(0, 1) == 0) ? limit + 1
                                                  : $urandom_range(limit + 1, 32'h7FFF_FFFF);
        end else begin
            case ($urandom_range(0, 2))
                0: configure(1'b1, $urandom);
                1: configure(1'b0, 32'h8000_0000 | $urandom);
                default: configure(1'b0, 32'h7FFF_FFFF);
            endcase
            send_frame(pick_length(8));
            case ($urandom_range(0, 4))
                0: bad_len = 32'h8000_0000;
                1: bad_len = 32'hFFFF_FFFF;
                2: bad_len = 32'h8000_0000 | $urandom;
                3: bad_len = MAX_PAYLOAD + 1;
                default: bad_len = $urandom_range(MAX_PAYLOAD + 1, 32'h7FFF_FFFF);
            endcase
        end
        send_header(bad_len);

        // The halted block must swallow everything that follows.
        repeat (20)
            send_byte(8'($urandom));

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.close_out() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[length_prefix_deframer.f]
sv/lpd_pkg.sv
sv/length_prefix_deframer.sv
tb/tb_length_prefix_deframer.sv
